// ----- design/assert_macros.svh -----
// Assertion macros for the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: consequent does not hold");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: consequent does not follow");

`else

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- design/tbc_pkg.sv -----
// Package with the types and constants of the blob centroid block.
`timescale 1ns / 1ps

package tbc_pkg;

    localparam int CFG_THR_W  = 8;
    localparam int CFG_SIZE_W = 11;
    localparam int PIXEL_W    = 8;
    localparam int CENTER_W   = 16;
    localparam int CNT_W      = 21;

    localparam logic [CNT_W-1:0]      CNT_MAX    = 21'h1F_FFFF;
    localparam logic [CENTER_W-1:0]   CENTER_MAX = 16'hFFFF;

    localparam logic [CFG_THR_W-1:0]  THRESHOLD_RESET = 8'h80;
    localparam logic [CFG_SIZE_W-1:0] WIDTH_RESET     = 11'd640;
    localparam logic [CFG_SIZE_W-1:0] HEIGHT_RESET    = 11'd480;

    // Frame records waiting for the divider.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        REG_THRESHOLD    = 2'd0,
        REG_FRAME_WIDTH  = 2'd1,
        REG_FRAME_HEIGHT = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [CFG_THR_W-1:0]  threshold;
        logic [CFG_SIZE_W-1:0] frame_width;
        logic [CFG_SIZE_W-1:0] frame_height;
    } t_cfg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_X,
        ST_DIV_Y,
        ST_DONE
    } t_back_state;

endpackage

// ----- design/tbc_if.sv -----
// Valid/ready channel interfaces for pixels and centroid results.
`timescale 1ns / 1ps

interface tbc_pix_if import tbc_pkg::*;;
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

interface tbc_res_if import tbc_pkg::*;;
    logic                valid;
    logic                ready;
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
    logic [CNT_W-1:0]    bright_count;
    logic                empty_frame;

    modport source (output valid, output center_x, output center_y,
                    output bright_count, output empty_frame, input ready);
    modport sink   (input valid, input center_x, input center_y,
                    input bright_count, input empty_frame, output ready);
endinterface

// ----- design/tbc_front.sv -----
// Front end: raster position tracking, thresholding and per-frame sums.
`timescale 1ns / 1ps

module tbc_front import tbc_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int SUMW       = 30,
    parameter int DATA_W     = 2 * SUMW + CNT_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    tbc_pix_if.sink           i_pix,
    output logic              o_push_valid,
    input  logic              i_push_ready,
    output logic [DATA_W-1:0] o_push_data
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int WBW  = $clog2(MAX_WIDTH + 1);
    localparam int HBW  = $clog2(MAX_HEIGHT + 1);
    localparam int WSW  = (WBW > CFG_SIZE_W) ? WBW : CFG_SIZE_W;
    localparam int HSW  = (HBW > CFG_SIZE_W) ? HBW : CFG_SIZE_W;

    logic [CW-1:0]    r_col;
    logic [RW-1:0]    r_row;
    logic [SUMW-1:0]  r_sx, n_sx;
    logic [SUMW-1:0]  r_sy, n_sy;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic [WSW-1:0] w_width_ext, w_width;
    logic [HSW-1:0] w_height_ext, w_height;
    logic           w_hit, w_row_end, w_frame_end, w_accept;

    // A size of zero acts as one; sizes past the maximum saturate.
    always_comb begin
        w_width_ext  = WSW'(i_cfg.frame_width);
        w_height_ext = HSW'(i_cfg.frame_height);
        if (w_width_ext == '0) begin
            w_width = WSW'(1);
        end else if (w_width_ext > WSW'(MAX_WIDTH)) begin
            w_width = WSW'(MAX_WIDTH);
        end else begin
            w_width = w_width_ext;
        end
        if (w_height_ext == '0) begin
            w_height = HSW'(1);
        end else if (w_height_ext > HSW'(MAX_HEIGHT)) begin
            w_height = HSW'(MAX_HEIGHT);
        end else begin
            w_height = w_height_ext;
        end
    end

    always_comb begin
        w_hit       = i_pix.pixel_value > i_cfg.threshold;
        w_row_end   = (WSW'(r_col) + WSW'(1)) >= w_width;
        w_frame_end = w_row_end && ((HSW'(r_row) + HSW'(1)) >= w_height);
        n_sx  = w_hit ? r_sx + SUMW'(r_col) : r_sx;
        n_sy  = w_hit ? r_sy + SUMW'(r_row) : r_sy;
        n_cnt = (w_hit && (r_cnt != CNT_MAX)) ? r_cnt + 1'b1 : r_cnt;
    end

    // Stall while the queue is full so the frame record always has a slot.
    assign i_pix.ready  = i_push_ready;
    assign w_accept     = i_pix.valid && i_pix.ready;
    assign o_push_valid = w_accept && w_frame_end;
    assign o_push_data  = {n_sx, n_sy, n_cnt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_sx  <= '0;
            r_sy  <= '0;
            r_cnt <= '0;
        end else if (w_accept) begin
            if (w_frame_end) begin
                r_col <= '0;
                r_row <= '0;
                r_sx  <= '0;
                r_sy  <= '0;
                r_cnt <= '0;
            end else begin
                r_sx  <= n_sx;
                r_sy  <= n_sy;
                r_cnt <= n_cnt;
                if (w_row_end) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

endmodule

// ----- design/tbc_queue.sv -----
// Short queue of frame records between the front end and the divider.
`timescale 1ns / 1ps

module tbc_queue import tbc_pkg::*; #(
    parameter int DATA_W = 81
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  logic [DATA_W-1:0] i_push_data,
    output logic              o_pop_valid,
    input  logic              i_pop_ready,
    output logic [DATA_W-1:0] o_pop_data
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [PW-1:0]     r_wr_ptr, r_rd_ptr;
    logic [NW-1:0]     r_fill;
    logic              w_push, w_pop;

    assign o_push_ready = r_fill != NW'(QUEUE_DEPTH);
    assign o_pop_valid  = r_fill != '0;
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (w_pop && !w_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

// ----- design/tbc_back.sv -----
// Back end: shared restoring divider for both centroids and the result register.
`timescale 1ns / 1ps

module tbc_back import tbc_pkg::*; #(
    parameter int SUMW      = 30,
    parameter int FRAC_BITS = 6,
    parameter int DATA_W    = 2 * SUMW + CNT_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_pop_valid,
    output logic              o_pop_ready,
    input  logic [DATA_W-1:0] i_pop_data,
    tbc_res_if.source         o_res
);

    localparam int DW  = SUMW + FRAC_BITS;
    localparam int STW = $clog2(DW);
    localparam int RMW = CNT_W + 1;

    t_back_state r_state, n_state;

    logic [DW-1:0]       r_dvd;
    logic [DW-1:0]       r_quo;
    logic [RMW-1:0]      r_rem;
    logic [STW-1:0]      r_step;
    logic [SUMW-1:0]     r_sy;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_empty;
    logic [CENTER_W-1:0] r_cx, r_cy;

    logic                r_out_valid;
    logic [CENTER_W-1:0] r_out_cx, r_out_cy;
    logic [CNT_W-1:0]    r_out_cnt;
    logic                r_out_empty;

    logic [SUMW-1:0]     w_sx, w_sy;
    logic [CNT_W-1:0]    w_cnt;
    logic [RMW-1:0]      w_rem_sh, w_rem_nx;
    logic [DW-1:0]       w_quo_nx;
    logic                w_ge, w_last, w_sat;
    logic [CENTER_W-1:0] w_center;
    logic                w_take, w_div_active, w_load_out;

    assign w_sx  = i_pop_data[DATA_W-1 -: SUMW];
    assign w_sy  = i_pop_data[CNT_W +: SUMW];
    assign w_cnt = i_pop_data[CNT_W-1:0];

    // One quotient bit per cycle.
    always_comb begin
        w_rem_sh = {r_rem[CNT_W-1:0], r_dvd[DW-1]};
        w_ge     = w_rem_sh >= {1'b0, r_cnt};
        w_rem_nx = w_ge ? w_rem_sh - {1'b0, r_cnt} : w_rem_sh;
        w_quo_nx = {r_quo[DW-2:0], w_ge};
        w_sat    = w_quo_nx > DW'(CENTER_MAX);
        w_center = w_sat ? CENTER_MAX : CENTER_W'(w_quo_nx);
        w_last   = r_step == STW'(DW - 1);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_pop_valid) begin
                    n_state = (w_cnt == '0) ? ST_DONE : ST_DIV_X;
                end
            end
            ST_DIV_X: begin
                if (w_last) begin
                    n_state = ST_DIV_Y;
                end
            end
            ST_DIV_Y: begin
                if (w_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop_ready  = 1'b0;
        w_div_active = 1'b0;
        w_load_out   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_pop_ready = 1'b1;
            end
            ST_DIV_X, ST_DIV_Y: begin
                w_div_active = 1'b1;
            end
            ST_DONE: begin
                w_load_out = !r_out_valid || o_res.ready;
            end
            default: begin
                o_pop_ready = 1'b0;
            end
        endcase
    end

    assign w_take = o_pop_ready && i_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_dvd   <= DW'(w_sx) << FRAC_BITS;
            r_sy    <= w_sy;
            r_cnt   <= w_cnt;
            r_empty <= w_cnt == '0;
            r_rem   <= '0;
            r_quo   <= '0;
            r_step  <= '0;
            r_cx    <= '0;
            r_cy    <= '0;
        end else if (w_div_active) begin
            if (w_last) begin
                r_rem  <= '0;
                r_quo  <= '0;
                r_step <= '0;
                // The row sum takes the divider over once the column quotient is in.
                if (r_state == ST_DIV_X) begin
                    r_cx  <= w_center;
                    r_dvd <= DW'(r_sy) << FRAC_BITS;
                end else begin
                    r_cy <= w_center;
                end
            end else begin
                r_dvd  <= r_dvd << 1;
                r_rem  <= w_rem_nx;
                r_quo  <= w_quo_nx;
                r_step <= r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_cx    <= r_cx;
            r_out_cy    <= r_cy;
            r_out_cnt   <= r_cnt;
            r_out_empty <= r_empty;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.center_x     = r_out_cx;
    assign o_res.center_y     = r_out_cy;
    assign o_res.bright_count = r_out_cnt;
    assign o_res.empty_frame  = r_out_empty;

endmodule

// ----- design/threshold_blob_centroid_top.sv -----
// Top level of the thresholded blob centroid block.
// Pixels are taken one per cycle; the input stalls only when two frame results wait.
// The shared divider works out the column centroid, then the row centroid, one frame at a time.
// A result passes the queue, the divider and the result register; an empty frame skips the divider.
// Synchronous active-low reset clears position, sums, queue and result; registers
// return to threshold 128, width 640, height 480.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module threshold_blob_centroid_top import tbc_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int FRAC_BITS  = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tbc_pix_if.sink     i_pix,
    tbc_res_if.source   o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(MAX_HEIGHT);
    localparam int SUMW   = CW + RW + ((CW > RW) ? CW : RW);
    localparam int DATA_W = 2 * SUMW + CNT_W;

    t_cfg              r_cfg;
    t_reg_idx          w_idx;
    logic              w_wr;
    logic              w_push_valid, w_push_ready, w_pop_valid, w_pop_ready;
    logic [DATA_W-1:0] w_push_data, w_pop_data;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold    <= THRESHOLD_RESET;
            r_cfg.frame_width  <= WIDTH_RESET;
            r_cfg.frame_height <= HEIGHT_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_THRESHOLD:    r_cfg.threshold    <= pwdata[CFG_THR_W-1:0];
                REG_FRAME_WIDTH:  r_cfg.frame_width  <= pwdata[CFG_SIZE_W-1:0];
                REG_FRAME_HEIGHT: r_cfg.frame_height <= pwdata[CFG_SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_THRESHOLD:    prdata = 32'(r_cfg.threshold);
            REG_FRAME_WIDTH:  prdata = 32'(r_cfg.frame_width);
            REG_FRAME_HEIGHT: prdata = 32'(r_cfg.frame_height);
            default:          prdata = '0;
        endcase
    end

    tbc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .SUMW       (SUMW),
        .DATA_W     (DATA_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_pix        (i_pix),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_data  (w_push_data)
    );

    tbc_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_data),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_data   (w_pop_data)
    );

    tbc_back #(
        .SUMW      (SUMW),
        .FRAC_BITS (FRAC_BITS),
        .DATA_W    (DATA_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_pop_valid),
        .o_pop_ready (w_pop_ready),
        .i_pop_data  (w_pop_data),
        .o_res       (o_res)
    );

    // An empty frame reports a zero centroid and count; a non-empty one a nonzero count.
    `ASSERT_IMPLY(a_empty_zero, i_clk, i_rst_n, o_res.valid && o_res.empty_frame, (o_res.center_x == '0) && (o_res.center_y == '0) && (o_res.bright_count == '0))
    `ASSERT_IMPLY(a_full_count, i_clk, i_rst_n, o_res.valid && !o_res.empty_frame, o_res.bright_count != '0)
    // A frame record pushed into the queue is visible to the divider next cycle.
    `ASSERT_NEXT(a_push_seen, i_clk, i_rst_n, w_push_valid && w_push_ready, w_pop_valid)

endmodule

// ----- dv/threshold_blob_centroid_top_tb.sv -----
// Self-checking testbench for the thresholded blob centroid block.
`timescale 1ns / 1ps

module threshold_blob_centroid_top_tb;
    import tbc_pkg::*;

    localparam int FRAC_BITS     = 6;
    localparam int MAX_SIDE      = 1024;
    localparam int SETTLE_CYCLES = 300;
    localparam int CHUNK_ITEMS   = 30;

    typedef struct {
        logic [CENTER_W-1:0] center_x;
        logic [CENTER_W-1:0] center_y;
        logic [CNT_W-1:0]    bright_count;
        logic                empty_frame;
    } t_centroid_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tbc_pix_if pix_bus ();
    tbc_res_if res_bus ();

    threshold_blob_centroid_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_bus),
        .o_res   (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow of the configuration and of the frame accumulators.
    logic [CFG_THR_W-1:0]  cfg_threshold = THRESHOLD_RESET;
    logic [CFG_SIZE_W-1:0] cfg_width     = WIDTH_RESET;
    logic [CFG_SIZE_W-1:0] cfg_height    = HEIGHT_RESET;
    int unsigned           cur_column    = 0;
    int unsigned           cur_row       = 0;
    longint unsigned       column_sum    = 0;
    longint unsigned       row_sum       = 0;
    logic [CNT_W-1:0]      bright_tally  = '0;

    t_centroid_result expected_centroids[$];
    logic [PIXEL_W-1:0] pending_pixels[$];
    int pixels_queued   = 0;
    int pixels_accepted = 0;
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int mismatch_count  = 0;

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic int unsigned clamp_side(input logic [CFG_SIZE_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_SIDE) return MAX_SIDE;
        return 32'(v);
    endfunction

    function automatic logic [CENTER_W-1:0] scaled_mean(input longint unsigned sum,
                                                        input logic [CNT_W-1:0] count);
        longint unsigned q;
        q = (sum << FRAC_BITS) / count;
        if (q > CENTER_MAX) q = CENTER_MAX;
        return q[CENTER_W-1:0];
    endfunction

    // Advances the frame position by one pixel and queues a result at frame end.
    function automatic void accumulate_pixel(input logic [PIXEL_W-1:0] px);
        int unsigned      w;
        int unsigned      h;
        logic             row_end;
        t_centroid_result res;
        w = clamp_side(cfg_width);
        h = clamp_side(cfg_height);
        if (px > cfg_threshold) begin
            column_sum += cur_column;
            row_sum    += cur_row;
            if (bright_tally != CNT_MAX) bright_tally++;
        end
        row_end = (cur_column + 1 >= w);
        if (row_end && (cur_row + 1 >= h)) begin
            if (bright_tally == 0) begin
                res = '{center_x: '0, center_y: '0, bright_count: '0, empty_frame: 1'b1};
            end else begin
                res.center_x     = scaled_mean(column_sum, bright_tally);
                res.center_y     = scaled_mean(row_sum, bright_tally);
                res.bright_count = bright_tally;
                res.empty_frame  = 1'b0;
            end
            expected_centroids.push_back(res);
            cur_column   = 0;
            cur_row      = 0;
            column_sum   = 0;
            row_sum      = 0;
            bright_tally = '0;
        end else if (row_end) begin
            cur_column = 0;
            cur_row++;
        end else begin
            cur_column++;
        end
    endfunction

    // Pixel driver: the shadow model advances on every accepted transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_bus.valid <= 1'b0;
        end else begin
            if (pix_bus.valid && pix_bus.ready) begin
                accumulate_pixel(pix_bus.pixel_value);
                pixels_accepted++;
            end
            if (!pix_bus.valid || pix_bus.ready) begin
                if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    pix_bus.valid       <= 1'b1;
                    pix_bus.pixel_value <= pending_pixels.pop_front();
                end else begin
                    pix_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge i_clk) begin
        t_centroid_result want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (expected_centroids.size() == 0) begin
                report_mismatch($sformatf("unexpected result x=%0d y=%0d count=%0d empty=%0b",
                    res_bus.center_x, res_bus.center_y, res_bus.bright_count,
                    res_bus.empty_frame));
            end else begin
                want = expected_centroids.pop_front();
                if (res_bus.center_x !== want.center_x)
                    report_mismatch($sformatf("center_x %0d, want %0d",
                        res_bus.center_x, want.center_x));
                if (res_bus.center_y !== want.center_y)
                    report_mismatch($sformatf("center_y %0d, want %0d",
                        res_bus.center_y, want.center_y));
                if (res_bus.bright_count !== want.bright_count)
                    report_mismatch($sformatf("bright_count %0d, want %0d",
                        res_bus.bright_count, want.bright_count));
                if (res_bus.empty_frame !== want.empty_frame)
                    report_mismatch($sformatf("empty_frame %0b, want %0b",
                        res_bus.empty_frame, want.empty_frame));
            end
        end
        res_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic read_register(input t_reg_idx idx, input logic [31:0] want);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== want)
            report_mismatch($sformatf("%s reads %0d, want %0d", idx.name(), prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Unused upper data bits carry noise; the register keeps only its own width.
    task automatic write_register(input t_reg_idx idx, input logic [CFG_SIZE_W-1:0] value);
        logic [31:0] data;
        data = $urandom;
        if (idx == REG_THRESHOLD) data[CFG_THR_W-1:0] = value[CFG_THR_W-1:0];
        else data[CFG_SIZE_W-1:0] = value;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_THRESHOLD:    cfg_threshold = data[CFG_THR_W-1:0];
            REG_FRAME_WIDTH:  cfg_width     = data[CFG_SIZE_W-1:0];
            REG_FRAME_HEIGHT: cfg_height    = data[CFG_SIZE_W-1:0];
            default: ;
        endcase
        read_register(idx, idx == REG_THRESHOLD ? 32'(cfg_threshold) : 32'(value));
    endtask

    task automatic set_frame(input logic [CFG_THR_W-1:0] thr,
                             input logic [CFG_SIZE_W-1:0] w, input logic [CFG_SIZE_W-1:0] h);
        write_register(REG_THRESHOLD, CFG_SIZE_W'(thr));
        write_register(REG_FRAME_WIDTH, w);
        write_register(REG_FRAME_HEIGHT, h);
    endtask

    task automatic queue_pixel(input logic [PIXEL_W-1:0] v);
        pending_pixels.push_back(v);
        pixels_queued++;
    endtask

    // Waits until every pixel is taken and every frame result has come back.
    task automatic wait_drained();
        while (pixels_accepted != pixels_queued || expected_centroids.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Density is the percent above the threshold of pixels that are not fully random.
    function automatic logic [PIXEL_W-1:0] random_pixel(input int density);
        if (cfg_threshold == 8'hFF || $urandom_range(0, 9) == 0)
            return PIXEL_W'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < density)
            return PIXEL_W'($urandom_range(cfg_threshold + 1, 255));
        return PIXEL_W'($urandom_range(0, cfg_threshold));
    endfunction

    function automatic logic [CFG_SIZE_W-1:0] random_side();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return CFG_SIZE_W'($urandom_range(9, 20));
            default: return CFG_SIZE_W'($urandom_range(1, 6));
        endcase
    endfunction

    task automatic run_random_chunk(input int n_items);
        logic [CFG_THR_W-1:0] thr;
        int                   density;
        case ($urandom_range(0, 3))
            0: thr = '0;
            1: thr = '1;
            default: thr = CFG_THR_W'($urandom_range(0, 255));
        endcase
        set_frame(thr, random_side(), random_side());
        density = $urandom_range(0, 100);
        repeat (n_items) queue_pixel(random_pixel(density));
        wait_drained();
    endtask

    initial begin
        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        pix_bus.valid       = 1'b0;
        pix_bus.pixel_value = '0;
        res_bus.ready       = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        read_register(REG_THRESHOLD, 32'(THRESHOLD_RESET));
        read_register(REG_FRAME_WIDTH, 32'(WIDTH_RESET));
        read_register(REG_FRAME_HEIGHT, 32'(HEIGHT_RESET));

        // A two-by-two frame around the threshold boundary, then one with nothing bright.
        set_frame(8'd128, 11'd2, 11'd2);
        queue_pixel(8'd255);
        queue_pixel(8'd128);
        queue_pixel(8'd129);
        queue_pixel(8'd0);
        queue_pixel(8'd128);
        queue_pixel(8'd0);
        queue_pixel(8'd100);
        queue_pixel(8'd128);
        wait_drained();

        // Shrinking the width in mid-frame ends the current row and frame at once.
        write_register(REG_THRESHOLD, 11'd0);
        queue_pixel(8'd0);
        queue_pixel(8'd1);
        queue_pixel(8'd255);
        wait_drained();
        write_register(REG_FRAME_WIDTH, 11'd1);
        queue_pixel(8'd0);
        wait_drained();

        // A zero size acts as one, so every pixel is a frame of its own.
        set_frame(8'd255, 11'd0, 11'd0);
        queue_pixel(8'd255);
        queue_pixel(8'd0);
        wait_drained();
        write_register(REG_THRESHOLD, 11'd254);
        queue_pixel(8'd255);
        wait_drained();

        for (int mode = 0; mode < 4; mode++) begin
            case (mode)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            repeat (2) run_random_chunk(CHUNK_ITEMS);
            if (mode == 0) begin
                // An oversized width saturates to the largest frame side.
                set_frame(CFG_THR_W'($urandom_range(0, 255)), 11'd2047, 11'd1);
                repeat (MAX_SIDE) queue_pixel(random_pixel(50));
                wait_drained();
            end
        end

        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
